// ===== src/dcce_pkg.sv =====
// Package for the don't-care cube enumerator.
// Holds the shared widths, cube codes, register indexes, the controller states
// and the structs that travel between the controller and the row of cells.
package dcce_pkg;

   localparam int CUBE_BITS = 64;   // result cube, two bits per position
   localparam int CFG_BITS  = 6;    // width of each configuration register
   localparam int POS_BITS  = 5;    // stored don't-care position
   localparam int CNT_BITS  = 32;   // assignment counter
   localparam int BIT_BITS  = 6;    // remaining free-bit count, 0 to 32

   localparam logic [CFG_BITS-1:0] CUBE_WIDTH_RESET = 6'd8;
   localparam logic [CFG_BITS-1:0] DC_COUNT_RESET   = 6'd0;

   // Register indexes on the csr port.
   localparam logic CSR_CUBE_WIDTH = 1'b0;
   localparam logic CSR_DC_COUNT   = 1'b1;

   // Two-bit codes of one cube position.
   localparam logic [1:0] CODE_UNUSED = 2'd0;
   localparam logic [1:0] CODE_ZERO   = 2'd1;
   localparam logic [1:0] CODE_ONE    = 2'd2;
   localparam logic [1:0] CODE_DC     = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_SEARCH,
      ST_FIN
   } state_type;

   // Scan token handed from one cell to the next.
   typedef struct packed {
      logic                valid;
      logic [BIT_BITS-1:0] bit_idx;
   } tok_type;

   // Controls broadcast to every cell.
   typedef struct packed {
      logic                init;     // restore entry i = i
      logic                load;     // reload the tail of the combination
      logic [POS_BITS-1:0] lo_idx;   // first cell of the reloaded tail
      logic [POS_BITS-1:0] base;     // new tail value is base + cell index
      logic [CFG_BITS-1:0] lv;       // don't-care count
      logic [CFG_BITS-1:0] k;        // effective cube width
   } cell_ctrl_type;

endpackage

// ===== src/dcce_cell.sv =====
// One cell of the enumerator row: one stored don't-care position and the
// code of one cube position. Depends on dcce_pkg for the token and control structs.
module dcce_cell
   import dcce_pkg::*;
#(
   parameter int IDX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  cell_ctrl_type       ctrl,
   input  logic                dc_hit,
   input  logic [CNT_BITS-1:0] counter,
   input  tok_type             tok_in,
   output tok_type             tok_out,
   output logic [POS_BITS-1:0] pos,
   output logic [1:0]          code
);

   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic [1:0]          code_ff, code_in;
   tok_type             tok_ff, tok_in_nx;
   logic [BIT_BITS-1:0] bit_dec;
   logic                in_tail;

   always_comb begin
      bit_dec   = tok_in.bit_idx - 6'd1;
      tok_in_nx = tok_in;
      code_in   = code_ff;
      if (tok_in.valid) begin
         if (6'(IDX) >= ctrl.k) begin
            code_in = CODE_UNUSED;
         end else if (dc_hit) begin
            code_in = CODE_DC;
         end else if (tok_in.bit_idx != '0) begin
            // The highest remaining counter bit goes to this free position.
            code_in           = counter[bit_dec[POS_BITS-1:0]] ? CODE_ONE : CODE_ZERO;
            tok_in_nx.bit_idx = bit_dec;
         end else begin
            code_in = CODE_ZERO;
         end
      end
   end

   assign in_tail = (6'(IDX) >= {1'b0, ctrl.lo_idx}) && (6'(IDX) < ctrl.lv);

   always_comb begin
      pos_in = pos_ff;
      if (ctrl.init) begin
         pos_in = POS_BITS'(IDX);
      end else if (ctrl.load && in_tail) begin
         pos_in = ctrl.base + POS_BITS'(IDX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_BITS'(IDX);
         tok_ff.valid <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         tok_ff.valid <= tok_in_nx.valid;
      end
      tok_ff.bit_idx <= tok_in_nx.bit_idx;
      code_ff        <= code_in;
   end

   assign tok_out = tok_ff;
   assign pos     = pos_ff;
   assign code    = code_ff;

endmodule

// ===== src/dont_care_cube_enumerator.sv =====
// Top level of the don't-care cube enumerator: csr registers, controller and
// the row of dcce_cell instances. Depends on dcce_pkg and dcce_cell.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_stall  req_restart
//   rsp       out        rsp_valid/rsp_stall  rsp_cube, rsp_cube_valid, rsp_is_last
//   csr       in         csr_write            csr_index, csr_data
//
// For each item a scan token walks the row of cells, one cell per cycle, and then,
// when the don't-care combination advances, a search walks from the top cell down;
// an exhausted answer goes from the idle state straight to the final state.
// Reset is synchronous and restores the first cube with width 8 and no don't-cares.
// A new request is taken while the previous result still waits under rsp_stall.
module dont_care_cube_enumerator
   import dcce_pkg::*;
#(
   parameter int MAX_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_restart,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [CUBE_BITS-1:0] rsp_cube,
   output logic                 rsp_cube_valid,
   output logic                 rsp_is_last,
   input  logic                 csr_write,
   input  logic                 csr_index,
   input  logic [CFG_BITS-1:0]  csr_data
);

   localparam int CW = $clog2(MAX_WIDTH);

   state_type            state_ff, state_in;
   logic [CFG_BITS-1:0]  cube_width_ff, dc_count_ff;
   logic [CNT_BITS-1:0]  counter_ff, counter_in;
   logic                 exh_ff, exh_in;
   logic [CFG_BITS-1:0]  a_ff, a_in;
   logic                 res_valid_ff, res_valid_in;
   logic                 res_last_ff, res_last_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CUBE_BITS-1:0] rsp_cube_ff, rsp_cube_in;
   logic                 rsp_cube_valid_ff, rsp_cube_valid_in;
   logic                 rsp_is_last_ff, rsp_is_last_in;

   logic [CFG_BITS-1:0]      k, lv, f, idx6, lim;
   logic                     exh_base;
   logic [CNT_BITS:0]        cnt_p1, cnt_lim;
   logic                     wrap;
   cell_ctrl_type            ctrl;
   tok_type                  tok_head;
   tok_type                  tok_link [MAX_WIDTH+1];
   logic [POS_BITS-1:0]      pos_arr  [MAX_WIDTH];
   logic [1:0]               code_arr [MAX_WIDTH];
   logic [(1<<POS_BITS)-1:0] dc_mask;
   logic [2*MAX_WIDTH-1:0]   cube_cells;
   logic [POS_BITS-1:0]      pos_sel;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cube_width_ff <= CUBE_WIDTH_RESET;
         dc_count_ff   <= DC_COUNT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_CUBE_WIDTH: cube_width_ff <= csr_data;
            CSR_DC_COUNT:   dc_count_ff   <= csr_data;
            default:        ;
         endcase
      end
   end

   assign k  = (cube_width_ff > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : cube_width_ff;
   assign lv = dc_count_ff;
   assign f  = k - lv;

   // The counter wraps once it reaches 2^f - 1.
   assign cnt_p1  = {1'b0, counter_ff} + 33'd1;
   assign cnt_lim = 33'd1 << f;
   assign wrap    = cnt_p1 >= cnt_lim;

   assign idx6    = a_ff - 6'd1;
   assign pos_sel = pos_arr[idx6[CW-1:0]];
   assign lim     = k - lv + idx6;

   // Set of positions currently marked don't-care.
   always_comb begin
      dc_mask = '0;
      for (int i = 0; i < MAX_WIDTH; i++) begin
         if (6'(i) < lv) begin
            dc_mask = dc_mask | ((1 << POS_BITS)'(1) << pos_arr[i]);
         end
      end
   end

   assign tok_link[0] = tok_head;

   genvar g;
   generate
      for (g = 0; g < MAX_WIDTH; g++) begin : g_cell
         dcce_cell #(
            .IDX (g)
         ) u_cell (
            .clock   (clock),
            .reset   (reset),
            .ctrl    (ctrl),
            .dc_hit  (dc_mask[g]),
            .counter (counter_ff),
            .tok_in  (tok_link[g]),
            .tok_out (tok_link[g+1]),
            .pos     (pos_arr[g]),
            .code    (code_arr[g])
         );
         assign cube_cells[2*g +: 2] = code_arr[g];
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         counter_ff   <= '0;
         exh_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         counter_ff   <= counter_in;
         exh_ff       <= exh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ff              <= a_in;
      res_valid_ff      <= res_valid_in;
      res_last_ff       <= res_last_in;
      rsp_cube_ff       <= rsp_cube_in;
      rsp_cube_valid_ff <= rsp_cube_valid_in;
      rsp_is_last_ff    <= rsp_is_last_in;
   end

   always_comb begin
      state_in          = state_ff;
      counter_in        = counter_ff;
      exh_in            = exh_ff;
      a_in              = a_ff;
      res_valid_in      = res_valid_ff;
      res_last_in       = res_last_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_cube_in       = rsp_cube_ff;
      rsp_cube_valid_in = rsp_cube_valid_ff;
      rsp_is_last_in    = rsp_is_last_ff;
      exh_base          = exh_ff;
      ctrl              = '{init: 1'b0, load: 1'b0, lo_idx: '0, base: '0, lv: lv, k: k};
      tok_head          = '{valid: 1'b0, bit_idx: f};
      req_stall         = (state_ff != ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctrl.init = req_restart;
               exh_base  = req_restart ? 1'b0 : exh_ff;
               if (req_restart) begin
                  counter_in = '0;
               end
               exh_in = exh_base || (lv > k);
               if (exh_in) begin
                  res_valid_in = 1'b0;
                  res_last_in  = 1'b0;
                  state_in     = ST_FIN;
               end else begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            tok_head.valid = 1'b1;
            state_in       = ST_SCAN;
         end
         ST_SCAN: begin
            if (tok_link[MAX_WIDTH].valid) begin
               res_valid_in = 1'b1;
               res_last_in  = 1'b0;
               if (wrap) begin
                  counter_in = '0;
                  if (lv == '0) begin
                     exh_in      = 1'b1;
                     res_last_in = 1'b1;
                     state_in    = ST_FIN;
                  end else begin
                     a_in     = lv;
                     state_in = ST_SEARCH;
                  end
               end else begin
                  counter_in = cnt_p1[CNT_BITS-1:0];
                  state_in   = ST_FIN;
               end
            end
         end
         ST_SEARCH: begin
            // Walk down from the top don't-care to the first one that can move.
            if ({1'b0, pos_sel} < lim) begin
               ctrl.load   = 1'b1;
               ctrl.lo_idx = idx6[POS_BITS-1:0];
               ctrl.base   = pos_sel + 5'd1 - idx6[POS_BITS-1:0];
               state_in    = ST_FIN;
            end else if (a_ff == 6'd1) begin
               exh_in      = 1'b1;
               res_last_in = 1'b1;
               state_in    = ST_FIN;
            end else begin
               a_in = a_ff - 6'd1;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in      = 1'b1;
               rsp_cube_in       = res_valid_ff ? CUBE_BITS'(cube_cells) : '0;
               rsp_cube_valid_in = res_valid_ff;
               rsp_is_last_in    = res_last_ff;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cube       = rsp_cube_ff;
   assign rsp_cube_valid = rsp_cube_valid_ff;
   assign rsp_is_last    = rsp_is_last_ff;

   // The token leaves the last cell only while the controller waits for it.
   a_scan_done: assert property (@(posedge clock) disable iff (reset)
      tok_link[MAX_WIDTH].valid |-> state_ff == ST_SCAN)
      else $error("scan token finished outside the scan state");

   // The search index always points at a stored don't-care position.
   a_search_idx: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEARCH |-> (a_ff != '0) && (a_ff <= lv))
      else $error("search index out of range");

   // An exhausted answer carries an empty cube and no last flag.
   a_exh_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_cube_valid_ff) |-> (rsp_cube_ff == '0) && !rsp_is_last_ff)
      else $error("exhausted answer carries data");

   // Leaving the final state always leaves a result behind.
   a_fin_out: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) == ST_FIN && state_ff == ST_IDLE) |-> rsp_valid_ff)
      else $error("result lost on leaving the final state");

endmodule

// ===== tb/sv/dont_care_cube_enumerator_tb.sv =====
// Testbench for dont_care_cube_enumerator: random and directed requests checked
// against a scoreboard class that predicts every cube. Depends on dcce_pkg and the RTL.
`timescale 1ns / 100ps

module dont_care_cube_enumerator_tb;
   import dcce_pkg::*;

   localparam int MAX_WIDTH = 32;
   localparam int TARGET_ITEMS = 1550;
   localparam int HOLD_OFF_CYCLES = 400;

   typedef struct {
      logic [CUBE_BITS-1:0] cube;
      logic                 cube_valid;
      logic                 is_last;
   } cube_result_type;

   class cube_scoreboard_type;
      logic [CFG_BITS-1:0] width_reg;
      logic [CFG_BITS-1:0] dc_reg;
      logic [POS_BITS-1:0] dc_pos [MAX_WIDTH];
      logic [CNT_BITS-1:0] assign_count;
      bit                  exhausted_flag;
      cube_result_type     pending_cubes [$];
      int unsigned         errors;
      int unsigned         n_checked;
      int unsigned         n_last;
      int unsigned         n_exhausted;

      function void clear_state();
         int i;
         width_reg = CUBE_WIDTH_RESET;
         dc_reg = DC_COUNT_RESET;
         for (i = 0; i < MAX_WIDTH; i++) dc_pos[i] = POS_BITS'(i);
         assign_count = '0;
         exhausted_flag = 0;
      endfunction

      function void set_register(logic idx, logic [CFG_BITS-1:0] value);
         if (idx == CSR_CUBE_WIDTH) width_reg = value;
         else dc_reg = value;
      endfunction

      // Steps the combination of don't-care positions; returns 0 once none is left.
      function bit advance_positions(int unsigned k, int unsigned lv);
         int unsigned a;
         int unsigned idx;
         int unsigned j;
         for (a = lv; a > 0; a--) begin
            idx = a - 1;
            if (int'(dc_pos[idx]) < k - lv + idx) begin
               dc_pos[idx] = dc_pos[idx] + 1'b1;
               for (j = idx + 1; j < lv; j++) dc_pos[j] = dc_pos[j-1] + 1'b1;
               return 1;
            end
         end
         return 0;
      endfunction

      function cube_result_type predict_cube(bit restart);
         int unsigned k;
         int unsigned lv;
         int unsigned free_bits;
         int unsigned bitn;
         int unsigned i;
         logic [31:0] dcmask;
         logic [63:0] last_count;
         logic [1:0]  code;
         cube_result_type r;
         k = 32'(width_reg);
         if (k > MAX_WIDTH) k = MAX_WIDTH;
         lv = 32'(dc_reg);
         r.cube = '0;
         r.cube_valid = 0;
         r.is_last = 0;
         if (restart) begin
            for (i = 0; i < MAX_WIDTH; i++) dc_pos[i] = POS_BITS'(i);
            assign_count = '0;
            exhausted_flag = 0;
         end
         if (lv > k) exhausted_flag = 1;
         if (exhausted_flag) return r;
         free_bits = k - lv;
         dcmask = '0;
         for (i = 0; i < lv && i < 32; i++) dcmask[dc_pos[i]] = 1'b1;
         // The counter's top bit lands on the lowest free position.
         bitn = free_bits;
         for (i = 0; i < k; i++) begin
            if (dcmask[i]) begin
               code = CODE_DC;
            end else begin
               code = CODE_ZERO;
               if (bitn > 0) begin
                  bitn--;
                  if (assign_count[bitn]) code = CODE_ONE;
               end
            end
            r.cube[2*i +: 2] = code;
         end
         r.cube_valid = 1;
         last_count = (64'd1 << free_bits) - 64'd1;
         if (64'(assign_count) >= last_count) begin
            assign_count = '0;
            if (!advance_positions(k, lv)) begin
               exhausted_flag = 1;
               r.is_last = 1;
            end
         end else begin
            assign_count = assign_count + 1'b1;
         end
         return r;
      endfunction

      function void note_request(bit restart);
         pending_cubes.push_back(predict_cube(restart));
      endfunction

      function void check_response(logic [CUBE_BITS-1:0] cube, logic cube_valid,
                                   logic is_last);
         cube_result_type want;
         if (pending_cubes.size() == 0) begin
            $error("response transfer with no request outstanding");
            errors++;
            return;
         end
         want = pending_cubes.pop_front();
         n_checked++;
         if (want.is_last) n_last++;
         if (!want.cube_valid) n_exhausted++;
         if (cube !== want.cube) begin
            $error("rsp_cube: expected %h, got %h", want.cube, cube);
            errors++;
         end
         if (cube_valid !== want.cube_valid) begin
            $error("rsp_cube_valid: expected %0b, got %0b", want.cube_valid, cube_valid);
            errors++;
         end
         if (is_last !== want.is_last) begin
            $error("rsp_is_last: expected %0b, got %0b", want.is_last, is_last);
            errors++;
         end
      endfunction

      function int outstanding();
         return pending_cubes.size();
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_restart = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [CUBE_BITS-1:0] rsp_cube;
   logic                 rsp_cube_valid;
   logic                 rsp_is_last;
   logic                 csr_write = 1'b0;
   logic                 csr_index = CSR_CUBE_WIDTH;
   logic [CFG_BITS-1:0]  csr_data = '0;

   cube_scoreboard_type sb;
   int unsigned         items_sent = 0;
   int unsigned         phases_run = 0;
   bit                  hold_off_request = 0;

   dont_care_cube_enumerator #(.MAX_WIDTH(MAX_WIDTH)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_restart(req_restart),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_cube(rsp_cube),
      .rsp_cube_valid(rsp_cube_valid), .rsp_is_last(rsp_is_last),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   initial begin
      sb = new;
      sb.clear_state();
   end

   // Every transfer and register write is taken at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write) sb.set_register(csr_index, csr_data);
         if (req_valid && !req_stall) sb.note_request(req_restart);
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_cube, rsp_cube_valid, rsp_is_last);
      end
   end

   initial begin : receiver
      int mode;
      int len;
      int held;
      forever begin
         if (hold_off_request) begin
            hold_off_request = 0;
            for (held = 0; held < HOLD_OFF_CYCLES; held++) begin
               @(negedge clock);
               rsp_stall <= 1'b1;
            end
         end
         mode = $urandom_range(0, 3);
         len = $urandom_range(5, 60);
         repeat (len) begin
            @(negedge clock);
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= 1'($urandom_range(0, 1));
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   task automatic send_request(bit restart);
      @(negedge clock);
      req_valid <= 1'b1;
      req_restart <= restart;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic write_csr(logic idx, logic [CFG_BITS-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // Waits until every predicted cube has come back, then lets the block settle.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (2 * MAX_WIDTH + 8) @(posedge clock);
   endtask

   task automatic run_phase(int w, int dc, int n_items, bit first_restart, bit hold);
      int sent_here;
      int burst;
      int gap;
      bit r;
      drain();
      write_csr(CSR_CUBE_WIDTH, CFG_BITS'(w));
      write_csr(CSR_DC_COUNT, CFG_BITS'(dc));
      if (hold) hold_off_request = 1;
      phases_run++;
      sent_here = 0;
      while (sent_here < n_items) begin
         burst = $urandom_range(1, 12);
         while (burst > 0 && sent_here < n_items) begin
            r = (sent_here == 0) ? first_restart : ($urandom_range(0, 29) == 0);
            send_request(r);
            sent_here++;
            burst--;
         end
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   initial begin : stimulus
      int sel;
      int w;
      int dc;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Cubes straight out of reset, then the corner cases of width and count.
      send_request(0);
      send_request(0);
      run_phase(0, 0, 2, 0, 0);      // empty cube, then exhausted
      run_phase(1, 1, 2, 1, 0);      // single don't-care cube, then exhausted
      run_phase(2, 3, 1, 1, 0);      // more don't-cares than positions
      run_phase(32, 32, 2, 1, 0);    // every position a don't-care
      run_phase(63, 0, 3, 1, 0);     // width saturates at the maximum
      run_phase(63, 63, 1, 1, 0);
      run_phase(3, 1, 13, 1, 0);     // full enumeration past its last cube

      while (items_sent < TARGET_ITEMS) begin
         sel = $urandom_range(0, 9);
         if (sel < 6) begin
            w = $urandom_range(0, 5);
            dc = $urandom_range(0, w);
         end else if (sel < 8) begin
            w = $urandom_range(6, 12);
            dc = $urandom_range(w - 3, w);
         end else if (sel == 8) begin
            w = $urandom_range(0, 63);
            dc = $urandom_range(0, 63);
         end else begin
            w = $urandom_range(0, 6);
            dc = w + $urandom_range(1, 3);
         end
         // One phase keeps the receiver stalled long enough to back up the input.
         if (phases_run == 20)
            run_phase(12, 10, 30, 1, 1);
         else
            run_phase(w, dc, $urandom_range(5, 40), $urandom_range(0, 3) != 0, 0);
      end

      drain();
      $display("Sent %0d requests over %0d register settings; checked %0d cubes,",
               items_sent, phases_run, sb.n_checked);
      $display("including %0d last cubes and %0d exhausted answers.",
               sb.n_last, sb.n_exhausted);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin : watchdog
      #40_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
